>>> rtl/eqf_pkg.sv
// Package for the three-band equalizer FIR unit: widths, codes, types and the gain table.
// Used by every module of the block except eqf_ram; depends on nothing.
package eqf_pkg;

  localparam int NUM_TAPS_DEF  = 256;
  localparam int NUM_BANDS     = 3;
  localparam int SAMPLE_W      = 16;
  localparam int COEF_W        = 16;
  localparam int TAP_W         = 8;
  localparam int BAND_W        = 2;
  localparam int GAIN_IDX_W    = 4;
  localparam int GAIN_W        = 15;
  localparam int PROD_W        = 32;
  localparam int LOADABLE_TAPS = 256;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_ONE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_TWO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_THREE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_DROP,
    OP_BYPASS,
    OP_FILTER
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic [BAND_W-1:0]         band;
    logic [TAP_W-1:0]          tap;
    logic signed [COEF_W-1:0]  coef;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } qitem_t;

  typedef logic [NUM_BANDS-1:0][GAIN_IDX_W-1:0] gain_set_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_START,
    BK_RUN,
    BK_DRAIN,
    BK_FINISH,
    BK_BYPASS
  } back_state_t;

  // Nine steps of 3 dB from -24 dB to just under 0 dB; indexes above eight saturate.
  function automatic logic [GAIN_W-1:0] gain_of(input logic [GAIN_IDX_W-1:0] idx);
    logic [GAIN_W-1:0] g;
    unique case (idx)
      4'd0:    g = 15'h080A;
      4'd1:    g = 15'h0B5B;
      4'd2:    g = 15'h100A;
      4'd3:    g = 15'h16A7;
      4'd4:    g = 15'h2000;
      4'd5:    g = 15'h2D34;
      4'd6:    g = 15'h3FD9;
      4'd7:    g = 15'h5A30;
      default: g = 15'h7F65;
    endcase
    return g;
  endfunction

endpackage

>>> rtl/eqf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the coefficient store and the delay lines.
module eqf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/eqf_front.sv
// Front end: accepts input words, classifies them into operations and queues them.
// Depends on eqf_pkg for the queue entry type and operation codes.
module eqf_front
  import eqf_pkg::*;
#(
  parameter int NUM_TAPS = NUM_TAPS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       func,
  input  logic [BAND_W-1:0]          band_index,
  input  logic [TAP_W-1:0]           tap_index,
  input  logic signed [COEF_W-1:0]   coef_value,
  input  logic signed [SAMPLE_W-1:0] left_in,
  input  logic signed [SAMPLE_W-1:0] right_in,
  input  logic                       filter_enable,
  output logic                       q_valid,
  output qitem_t                     q_item,
  input  logic                       q_pop
);

  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  qitem_t           slots [QDEPTH];
  logic [QPW-1:0]   wr_ptr;
  logic [QPW-1:0]   rd_ptr;
  logic [QCW-1:0]   count;
  logic             push;
  qitem_t           item;

  assign in_ready = (count != QCW'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_item   = slots[rd_ptr];

  always_comb begin
    item.band  = band_index;
    item.tap   = tap_index;
    item.coef  = coef_value;
    item.left  = left_in;
    item.right = right_in;
    if (func) begin
      item.op = filter_enable ? OP_FILTER : OP_BYPASS;
    end else if ((int'(band_index) < NUM_BANDS) && (int'(tap_index) < NUM_TAPS)) begin
      item.op = OP_LOAD;
    end else begin
      item.op = OP_DROP;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QPW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (q_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/eqf_back.sv
// Back end: executes queued operations, runs the shared multiply-accumulate pipeline
// and holds the output register. Depends on eqf_pkg and eqf_ram.
module eqf_back
  import eqf_pkg::*;
#(
  parameter int NUM_TAPS = NUM_TAPS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  qitem_t                     q_item,
  output logic                       q_pop,
  input  gain_set_t                  gains,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] left_out,
  output logic signed [SAMPLE_W-1:0] right_out
);

  localparam int AW    = $clog2(NUM_TAPS);
  localparam int CW    = $clog2(NUM_TAPS + 1);
  localparam int ACC_W = PROD_W + $clog2(NUM_TAPS);

  back_state_t state, state_next;

  logic coef_we, delay_we, issue, run_start, out_load, bypass_load, wp_adv;
  logic out_free;

  logic [AW-1:0] wp, rp, kcnt;
  logic [CW-1:0] fill;
  logic signed [SAMPLE_W-1:0] smp_l, smp_r;

  logic [NUM_BANDS-1:0][COEF_W-1:0] coef_rd;
  logic [SAMPLE_W-1:0] xl_rd, xr_rd;
  logic [NUM_BANDS-1:0][GAIN_W-1:0] gain_val;

  logic s1_valid, s1_last, s1_tap_ok, s1_x_ok;
  logic s2_valid, s2_last, s2_tap_ok;
  logic signed [PROD_W-1:0] s2_p [NUM_BANDS];
  logic signed [SAMPLE_W-1:0] s2_xl, s2_xr;
  logic s3_valid, s3_last;
  logic signed [COEF_W-1:0] s3_mixed;
  logic signed [SAMPLE_W-1:0] s3_xl, s3_xr;
  logic s4_valid, s4_last;
  logic signed [PROD_W-1:0] s4_ml, s4_mr;
  logic signed [ACC_W-1:0] acc_l, acc_r;

  logic [COEF_W-1:0] mixed_sum;
  logic signed [SAMPLE_W-1:0] fin_l, fin_r;

  assign out_free = !out_valid || out_ready;

  for (genvar b = 0; b < NUM_BANDS; b++) begin : g_band
    assign gain_val[b] = gain_of(gains[b]);
    eqf_ram #(.WIDTH(COEF_W), .DEPTH(NUM_TAPS)) u_coef (
      .clk   (clk),
      .we    (coef_we && (q_item.band == BAND_W'(b))),
      .waddr (AW'(q_item.tap)),
      .wdata (q_item.coef),
      .raddr (kcnt),
      .rdata (coef_rd[b])
    );
  end

  eqf_ram #(.WIDTH(SAMPLE_W), .DEPTH(NUM_TAPS)) u_delay_l (
    .clk   (clk),
    .we    (delay_we),
    .waddr (wp),
    .wdata (smp_l),
    .raddr (rp),
    .rdata (xl_rd)
  );

  eqf_ram #(.WIDTH(SAMPLE_W), .DEPTH(NUM_TAPS)) u_delay_r (
    .clk   (clk),
    .we    (delay_we),
    .waddr (wp),
    .wdata (smp_r),
    .raddr (rp),
    .rdata (xr_rd)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          unique case (q_item.op)
            OP_FILTER: state_next = BK_START;
            OP_BYPASS: state_next = BK_BYPASS;
            OP_LOAD:   state_next = BK_IDLE;
            OP_DROP:   state_next = BK_IDLE;
          endcase
        end
      end
      BK_START:  state_next = BK_RUN;
      BK_RUN: begin
        if (kcnt == AW'(NUM_TAPS - 1)) begin
          state_next = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (s4_valid && s4_last) begin
          state_next = BK_FINISH;
        end
      end
      BK_FINISH: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      BK_BYPASS: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop       = 1'b0;
    coef_we     = 1'b0;
    delay_we    = 1'b0;
    run_start   = 1'b0;
    issue       = 1'b0;
    wp_adv      = 1'b0;
    out_load    = 1'b0;
    bypass_load = 1'b0;
    unique case (state)
      BK_IDLE: begin
        q_pop   = q_valid;
        coef_we = q_valid && (q_item.op == OP_LOAD);
      end
      BK_START: begin
        delay_we  = 1'b1;
        run_start = 1'b1;
      end
      BK_RUN: begin
        issue  = 1'b1;
        wp_adv = (kcnt == AW'(NUM_TAPS - 1));
      end
      BK_DRAIN: begin
      end
      BK_FINISH: begin
        out_load = out_free;
      end
      BK_BYPASS: begin
        out_load    = out_free;
        bypass_load = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      wp    <= '0;
      fill  <= '0;
    end else begin
      state <= state_next;
      if (run_start && (fill != CW'(NUM_TAPS))) begin
        fill <= fill + 1'b1;
      end
      if (wp_adv) begin
        wp <= (wp == AW'(NUM_TAPS - 1)) ? '0 : wp + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      smp_l <= q_item.left;
      smp_r <= q_item.right;
    end
    if (run_start) begin
      kcnt <= '0;
      rp   <= wp;
    end else if (issue) begin
      kcnt <= kcnt + 1'b1;
      rp   <= (rp == '0) ? AW'(NUM_TAPS - 1) : rp - 1'b1;
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_comb begin
    mixed_sum = '0;
    for (int b = 0; b < NUM_BANDS; b++) begin
      mixed_sum = mixed_sum + s2_p[b][PROD_W-2:GAIN_W];
    end
  end

  always_ff @(posedge clk) begin
    s1_last   <= (kcnt == AW'(NUM_TAPS - 1));
    s1_tap_ok <= (int'(kcnt) < LOADABLE_TAPS);
    s1_x_ok   <= (CW'(kcnt) < fill);

    for (int b = 0; b < NUM_BANDS; b++) begin
      s2_p[b] <= $signed(coef_rd[b]) * $signed({1'b0, gain_val[b]});
    end
    s2_xl     <= s1_x_ok ? $signed(xl_rd) : '0;
    s2_xr     <= s1_x_ok ? $signed(xr_rd) : '0;
    s2_last   <= s1_last;
    s2_tap_ok <= s1_tap_ok;

    s3_mixed <= s2_tap_ok ? $signed(mixed_sum) : '0;
    s3_xl    <= s2_xl;
    s3_xr    <= s2_xr;
    s3_last  <= s2_last;

    s4_ml   <= s3_mixed * s3_xl;
    s4_mr   <= s3_mixed * s3_xr;
    s4_last <= s3_last;

    if (run_start) begin
      acc_l <= '0;
      acc_r <= '0;
    end else if (s4_valid) begin
      acc_l <= acc_l + ACC_W'(s4_ml);
      acc_r <= acc_r + ACC_W'(s4_mr);
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W:0]   rs;
    logic [ACC_W-PROD_W+2:0] hi;
    logic signed [SAMPLE_W-1:0] r;
    rs = (ACC_W + 1)'(a) + (ACC_W + 1)'(16'h4000);
    hi = rs[ACC_W:PROD_W-2];
    if ((&hi) || !(|hi)) begin
      r = rs[PROD_W-2:GAIN_W];
    end else if (rs[ACC_W]) begin
      r = 16'sh8000;
    end else begin
      r = 16'sh7FFF;
    end
    return r;
  endfunction

  assign fin_l = round_sat(acc_l);
  assign fin_r = round_sat(acc_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_out  <= bypass_load ? smp_l : fin_l;
      right_out <= bypass_load ? smp_r : fin_r;
    end
  end

  a_last_in_drain: assert property (@(posedge clk) disable iff (rst)
    (s4_valid && s4_last) |-> (state == BK_DRAIN))
    else $error("last product reached the accumulator outside the drain phase");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == BK_RUN && kcnt == AW'(NUM_TAPS - 1)) |=> (state == BK_DRAIN && !issue))
    else $error("tap sweep did not stop after the last tap");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten while a word waits");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(NUM_TAPS))
    else $error("delay line fill count beyond its depth");

endmodule

>>> rtl/three_band_equalizer_fir_unit.sv
// Top level of the three-band stereo equalizer FIR unit: configuration registers,
// front end with its queue and back end with the MAC pipeline. Depends on eqf_pkg,
// eqf_front, eqf_back and eqf_ram.
//
//   channel   signals                                   moves
//   input     in_valid / in_ready                       load or stereo sample word
//   output    out_valid / out_ready                     filtered or bypassed stereo word
//   config    cfg_we, cfg_index, cfg_data               gain steps and filter enable
//
// The back end computes a filtered sample one tap per cycle through a single
// multiply-accumulate pipeline fed by one read port on each coefficient and delay-line
// RAM, then drains the pipeline and rounds. Reset clears the queue, the write pointer and
// the delay-line fill count; unfilled delay entries read as zero. The two-entry queue and
// the output register let the input side keep accepting while a result waits.
module three_band_equalizer_fir_unit
  import eqf_pkg::*;
#(
  parameter int NUM_TAPS = NUM_TAPS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       func,
  input  logic [BAND_W-1:0]          band_index,
  input  logic [TAP_W-1:0]           tap_index,
  input  logic signed [COEF_W-1:0]   coef_value,
  input  logic signed [SAMPLE_W-1:0] left_in,
  input  logic signed [SAMPLE_W-1:0] right_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] left_out,
  output logic signed [SAMPLE_W-1:0] right_out,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  gain_set_t gains;
  logic      filter_enable;
  logic      q_valid;
  logic      q_pop;
  qitem_t    q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains         <= {NUM_BANDS{GAIN_IDX_W'(4)}};
      filter_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN_ONE:   gains[0]      <= cfg_data;
        CFG_GAIN_TWO:   gains[1]      <= cfg_data;
        CFG_GAIN_THREE: gains[2]      <= cfg_data;
        CFG_ENABLE:     filter_enable <= cfg_data[0];
      endcase
    end
  end

  eqf_front #(.NUM_TAPS(NUM_TAPS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .band_index    (band_index),
    .tap_index     (tap_index),
    .coef_value    (coef_value),
    .left_in       (left_in),
    .right_in      (right_in),
    .filter_enable (filter_enable),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  eqf_back #(.NUM_TAPS(NUM_TAPS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .gains     (gains),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .left_out  (left_out),
    .right_out (right_out)
  );

endmodule

>>> verif/three_band_equalizer_fir_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the three-band stereo equalizer FIR unit: directed corner words,
// a full coefficient load and randomized phases with idling on both channels.
// Depends on eqf_pkg and three_band_equalizer_fir_unit; results are predicted in a local class.
module three_band_equalizer_fir_unit_tb;
  import eqf_pkg::*;

  localparam int     TAPS          = NUM_TAPS_DEF;
  localparam bit     FUNC_LOAD     = 1'b0;
  localparam bit     FUNC_SAMPLE   = 1'b1;
  localparam logic [BAND_W-1:0] BAND_NONE = 2'd3;
  localparam int     SETTLE_CYCLES = TAPS + 24;
  localparam longint LIMIT_NS      = 64'd50_000_000;
  localparam int     REPORT_CAP    = 100;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } stereo_word_t;

  class eq_mirror;
    logic signed [COEF_W-1:0]   coef_mem [NUM_BANDS][LOADABLE_TAPS];
    logic signed [SAMPLE_W-1:0] left_hist [TAPS];
    logic signed [SAMPLE_W-1:0] right_hist [TAPS];
    int                         wr_pos;
    logic [GAIN_IDX_W-1:0]      gain_step [NUM_BANDS];
    bit                         filt_on;
    int                         gain_lut [9];
    stereo_word_t               stereo_due [$];
    int unsigned                mismatches;

    function new();
      gain_lut = '{32'h080A, 32'h0B5B, 32'h100A, 32'h16A7, 32'h2000,
                   32'h2D34, 32'h3FD9, 32'h5A30, 32'h7F65};
      foreach (left_hist[i]) begin
        left_hist[i]  = '0;
        right_hist[i] = '0;
      end
      foreach (gain_step[b]) gain_step[b] = 4'd4;
      wr_pos     = 0;
      filt_on    = 1'b0;
      mismatches = 0;
    endfunction

    function int pending();
      return stereo_due.size();
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GAIN_ONE:   gain_step[0] = data;
        CFG_GAIN_TWO:   gain_step[1] = data;
        CFG_GAIN_THREE: gain_step[2] = data;
        CFG_ENABLE:     filt_on = data[0];
        default: ;
      endcase
    endfunction

    function logic signed [COEF_W-1:0] mixed_tap(input int k);
      int sum;
      int prod;
      int g_idx;
      sum = 0;
      for (int b = 0; b < NUM_BANDS; b++) begin
        g_idx = (gain_step[b] > 8) ? 8 : int'(gain_step[b]);
        prod  = int'(coef_mem[b][k]) * gain_lut[g_idx];
        sum  += prod >>> 15;
      end
      return sum[15:0];
    endfunction

    function logic signed [SAMPLE_W-1:0] clamp16(input longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
    endfunction

    function stereo_word_t filter_pair(input logic signed [SAMPLE_W-1:0] l, r);
      longint       acc_l;
      longint       acc_r;
      longint       h;
      int           pos;
      stereo_word_t w;
      left_hist[wr_pos]  = l;
      right_hist[wr_pos] = r;
      acc_l = 0;
      acc_r = 0;
      for (int k = 0; k < TAPS; k++) begin
        pos    = (wr_pos + TAPS - k) % TAPS;
        h      = mixed_tap(k);
        acc_l += h * longint'(left_hist[pos]);
        acc_r += h * longint'(right_hist[pos]);
      end
      wr_pos  = (wr_pos + 1) % TAPS;
      w.left  = clamp16((acc_l + 64'sd16384) >>> 15);
      w.right = clamp16((acc_r + 64'sd16384) >>> 15);
      return w;
    endfunction

    function void accept_word(input logic f, input logic [BAND_W-1:0] b,
                              input logic [TAP_W-1:0] t, input logic signed [COEF_W-1:0] c,
                              input logic signed [SAMPLE_W-1:0] l, r);
      stereo_word_t w;
      if (f == FUNC_LOAD) begin
        if (b < NUM_BANDS) coef_mem[b][t] = c;
      end else if (!filt_on) begin
        w.left  = l;
        w.right = r;
        stereo_due.push_back(w);
      end else begin
        stereo_due.push_back(filter_pair(l, r));
      end
    endfunction

    function void check_word(input logic signed [SAMPLE_W-1:0] l, r);
      stereo_word_t w;
      if (stereo_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $error("unexpected word: left_out %0d, right_out %0d", l, r);
        return;
      end
      w = stereo_due.pop_front();
      if (w.left !== l) begin
        mismatches++;
        if (mismatches <= REPORT_CAP) $error("left_out: expected %0d, got %0d", w.left, l);
      end
      if (w.right !== r) begin
        mismatches++;
        if (mismatches <= REPORT_CAP) $error("right_out: expected %0d, got %0d", w.right, r);
      end
    endfunction
  endclass

  logic                       clk        = 1'b0;
  logic                       rst        = 1'b1;
  logic                       in_valid   = 1'b0;
  logic                       in_ready;
  logic                       func       = FUNC_LOAD;
  logic [BAND_W-1:0]          band_index = '0;
  logic [TAP_W-1:0]           tap_index  = '0;
  logic signed [COEF_W-1:0]   coef_value = '0;
  logic signed [SAMPLE_W-1:0] left_in    = '0;
  logic signed [SAMPLE_W-1:0] right_in   = '0;
  logic                       out_valid;
  logic                       out_ready  = 1'b0;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic                       cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index  = '0;
  logic [CFG_DATA_W-1:0]      cfg_data   = '0;

  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;
  eq_mirror mirror;

  three_band_equalizer_fir_unit u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) mirror.check_word(left_out, right_out);
      if (in_valid && in_ready)
        mirror.accept_word(func, band_index, tap_index, coef_value, left_in, right_in);
    end
  end

  function automatic logic signed [COEF_W-1:0] coef_draw();
    if ($urandom_range(0, 3) != 0) return 16'(int'($urandom_range(0, 511)) - 256);
    return 16'($urandom);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sample_draw();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'(int'($urandom_range(0, 127)) - 64);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic f, input logic [BAND_W-1:0] b, input logic [TAP_W-1:0] t,
                           input logic signed [COEF_W-1:0] c,
                           input logic signed [SAMPLE_W-1:0] l, r);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk);
    end
    in_valid   = 1'b1;
    func       = f;
    band_index = b;
    tap_index  = t;
    coef_value = c;
    left_in    = l;
    right_in   = r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_coef(input logic [BAND_W-1:0] b, input logic [TAP_W-1:0] t,
                           input logic signed [COEF_W-1:0] c);
    send_word(FUNC_LOAD, b, t, c, 16'($urandom), 16'($urandom));
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] l, r);
    send_word(FUNC_SAMPLE, 2'($urandom), 8'($urandom), 16'($urandom), l, r);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    do @(negedge clk); while (mirror.pending() != 0);
  endtask

  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    mirror.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] g1, g2, g3, en);
    settle();
    cfg_we = 1'b1;
    put_reg(CFG_GAIN_ONE, g1);
    put_reg(CFG_GAIN_TWO, g2);
    put_reg(CFG_GAIN_THREE, g3);
    put_reg(CFG_ENABLE, en);
    cfg_we = 1'b0;
  endtask

  task automatic random_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) load_coef(BAND_NONE, 8'($urandom), coef_draw());
    else if (pick < 30) load_coef(2'($urandom_range(0, 2)), 8'($urandom), coef_draw());
    else send_sample(sample_draw(), sample_draw());
  endtask

  task automatic run_phase(input int n, input int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) drain_results();
      random_word();
    end
  endtask

  initial begin
    mirror = new();
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Bypass words at the sample extremes; a load to the unused band must change nothing.
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh0000, -16'sd1);
    send_sample(16'sh5555, 16'shAAAA);
    load_coef(BAND_NONE, 8'hFF, 16'sh7FFF);
    set_regs(4'd4, 4'd4, 4'd4, 4'b0110);
    send_sample(16'sh0001, 16'shFFFE);

    // Every coefficient is written before the first filtered word reads the store.
    for (int b = 0; b < NUM_BANDS; b++)
      for (int t = 0; t < LOADABLE_TAPS; t++)
        load_coef(2'(b), 8'(t), coef_draw());

    // Full-scale coefficients at maximum gain make the mixed tap wrap.
    set_regs(4'd8, 4'd8, 4'd8, 4'd1);
    load_coef(2'd0, 8'd0, 16'sh7FFF);
    load_coef(2'd1, 8'd0, 16'sh7FFF);
    load_coef(2'd2, 8'd0, 16'sh7FFF);
    load_coef(BAND_NONE, 8'd0, 16'sh8000);
    load_coef(2'd0, 8'hFF, 16'sh8000);
    load_coef(2'd1, 8'hFF, 16'sh8000);
    load_coef(2'd2, 8'hFF, 16'sh8000);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh0000, 16'sh0000);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh0001, -16'sd1);

    set_regs(4'd0, 4'd0, 4'd0, 4'b1111);
    run_phase(25, -1);

    send_idle_pct = 88;
    set_regs(4'd8, 4'd8, 4'd8, 4'd1);
    run_phase(25, -1);

    send_idle_pct  = 0;
    recv_stall_pct = 88;
    set_regs(4'd9, 4'd15, 4'd12, 4'd1);
    run_phase(25, -1);

    send_idle_pct  = 22;
    recv_stall_pct = 22;
    set_regs(4'($urandom_range(0, 8)), 4'($urandom_range(0, 8)), 4'($urandom_range(0, 8)),
             4'd1);
    run_phase(25, -1);

    set_regs(4'($urandom), 4'($urandom), 4'($urandom), 4'b1000);
    run_phase(20, -1);

    send_idle_pct  = 0;
    recv_stall_pct = 88;
    set_regs(4'($urandom), 4'($urandom), 4'($urandom), 4'b0101);
    run_phase(30, 15);

    settle();
    if (mirror.mismatches == 0 && mirror.pending() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("FAIL");
    $finish;
  end

endmodule

>>> files.f
rtl/eqf_pkg.sv
rtl/eqf_ram.sv
rtl/eqf_front.sv
rtl/eqf_back.sv
rtl/three_band_equalizer_fir_unit.sv
verif/three_band_equalizer_fir_unit_tb.sv
